// File: hdl/rtet_pkg.sv
package rtet_pkg;

    localparam int MAX_MOTIF_DEF = 8;
    localparam int MAX_TRACT_DEF = 4096;

    localparam int CHAR_W    = 8;
    localparam int LEN_W     = 4;
    localparam int CFG_W     = 64;
    localparam int POS_OUT_W = 12;

    localparam logic [POS_OUT_W-1:0] POS_SAT = 12'd4095;

    typedef enum logic [0:0] {
        CFG_MOTIF_CHARS = 1'b0,
        CFG_MOTIF_LEN   = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [CHAR_W-1:0] base_char;
        logic              is_last;
    } in_t;

    typedef struct packed {
        logic                 found;
        logic [POS_OUT_W-1:0] trim_begin;
        logic [POS_OUT_W-1:0] trim_end;
        logic                 overlong;
    } out_t;

    function automatic logic [POS_OUT_W-1:0] sat_pos(input logic [31:0] v);
        logic [POS_OUT_W-1:0] r;
        if (v > 32'(POS_SAT)) begin
            r = POS_SAT;
        end else begin
            r = v[POS_OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/rtet_match.sv
module rtet_match #(
    parameter int MAX_MOTIF = rtet_pkg::MAX_MOTIF_DEF
) (
    input  logic [MAX_MOTIF*rtet_pkg::CHAR_W-1:0] window,
    input  logic [rtet_pkg::CFG_W-1:0]            motif,
    input  logic [rtet_pkg::LEN_W-1:0]            len,
    output logic                                  hit
);

    localparam int MIDX_W = (MAX_MOTIF > 1) ? $clog2(MAX_MOTIF) : 1;

    logic [rtet_pkg::CHAR_W-1:0] win_b [MAX_MOTIF];
    logic [rtet_pkg::CHAR_W-1:0] mot_b [MAX_MOTIF];

    always_comb begin
        for (int i = 0; i < MAX_MOTIF; i++) begin
            win_b[i] = window[i*rtet_pkg::CHAR_W +: rtet_pkg::CHAR_W];
            mot_b[i] = motif[i*rtet_pkg::CHAR_W +: rtet_pkg::CHAR_W];
        end
    end

    // window byte len-1-k (k-th oldest) against motif byte (r+k) mod len
    always_comb begin
        logic                     rot_ok;
        logic [MIDX_W-1:0]        widx;
        logic [MIDX_W-1:0]        midx;
        logic [rtet_pkg::LEN_W:0] s;
        hit = 1'b0;
        for (int r = 0; r < MAX_MOTIF; r++) begin
            rot_ok = 1'b1;
            for (int k = 0; k < MAX_MOTIF; k++) begin
                widx = MIDX_W'(int'(len) - 1 - k);
                s    = (rtet_pkg::LEN_W+1)'(r + k);
                if (s >= {1'b0, len}) begin
                    s = s - {1'b0, len};
                end
                midx = MIDX_W'(s);
                if (k < int'(len) && win_b[widx] != mot_b[midx]) begin
                    rot_ok = 1'b0;
                end
            end
            if (r < int'(len) && rot_ok) begin
                hit = 1'b1;
            end
        end
    end

endmodule

// File: hdl/rtet_core.sv
module rtet_core #(
    parameter int MAX_MOTIF = rtet_pkg::MAX_MOTIF_DEF,
    parameter int MAX_TRACT = rtet_pkg::MAX_TRACT_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_addr,
    input  logic [rtet_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                       step,
    input  rtet_pkg::in_t              item,
    output rtet_pkg::out_t             result
);

    localparam int WIN_W = MAX_MOTIF * rtet_pkg::CHAR_W;
    localparam int POS_W = $clog2(MAX_TRACT + 1);

    logic [rtet_pkg::CFG_W-1:0] motif_chars_reg;
    logic [rtet_pkg::LEN_W-1:0] motif_len_reg;

    logic [WIN_W-1:0]              window_reg,      window_next;
    logic [POS_W-1:0]              position_reg,    position_next;
    logic [rtet_pkg::POS_OUT_W-1:0] first_start_reg, first_start_next;
    logic [rtet_pkg::POS_OUT_W-1:0] last_end_reg,    last_end_next;
    logic                          seen_match_reg,  seen_match_next;
    logic                          too_long_reg,    too_long_next;

    logic [rtet_pkg::LEN_W-1:0] eff_len;
    logic [WIN_W-1:0]           window_shift;
    logic [POS_W-1:0]           start_pos;
    logic                       hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            motif_chars_reg <= '0;
            motif_len_reg   <= rtet_pkg::LEN_W'(1);
        end else if (cfg_we) begin
            if (cfg_addr == rtet_pkg::CFG_MOTIF_CHARS) begin
                motif_chars_reg <= cfg_wdata;
            end else begin
                motif_len_reg <= cfg_wdata[rtet_pkg::LEN_W-1:0];
            end
        end
    end

    always_comb begin
        priority if (motif_len_reg == '0) begin
            eff_len = rtet_pkg::LEN_W'(1);
        end else if (int'(motif_len_reg) > MAX_MOTIF) begin
            eff_len = rtet_pkg::LEN_W'(MAX_MOTIF);
        end else begin
            eff_len = motif_len_reg;
        end
    end

    generate
        if (MAX_MOTIF > 1) begin : g_shift
            assign window_shift = {window_reg[WIN_W-rtet_pkg::CHAR_W-1:0], item.base_char};
        end else begin : g_single
            assign window_shift = item.base_char;
        end
    endgenerate

    rtet_match #(
        .MAX_MOTIF (MAX_MOTIF)
    ) u_match (
        .window (window_shift),
        .motif  (motif_chars_reg),
        .len    (eff_len),
        .hit    (hit)
    );

    assign start_pos = POS_W'(position_reg + POS_W'(1) - POS_W'(eff_len));

    always_comb begin
        window_next      = window_reg;
        position_next    = position_reg;
        first_start_next = first_start_reg;
        last_end_next    = last_end_reg;
        seen_match_next  = seen_match_reg;
        too_long_next    = too_long_reg;

        if (position_reg >= POS_W'(MAX_TRACT)) begin
            too_long_next = 1'b1;
        end else begin
            window_next   = window_shift;
            position_next = POS_W'(position_reg + POS_W'(1));
            if ((POS_W+1)'(position_reg) + (POS_W+1)'(1) >= (POS_W+1)'(eff_len) && hit) begin
                if (!seen_match_reg) begin
                    first_start_next = rtet_pkg::sat_pos(32'(start_pos));
                    seen_match_next  = 1'b1;
                end
                last_end_next = rtet_pkg::sat_pos(32'(position_reg));
            end
        end

        result.found      = seen_match_next;
        result.trim_begin = seen_match_next ? first_start_next : '0;
        result.trim_end   = seen_match_next ? last_end_next : '0;
        result.overlong   = too_long_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg      <= '0;
            position_reg    <= '0;
            first_start_reg <= '0;
            last_end_reg    <= '0;
            seen_match_reg  <= 1'b0;
            too_long_reg    <= 1'b0;
        end else if (step) begin
            if (item.is_last) begin
                window_reg      <= '0;
                position_reg    <= '0;
                first_start_reg <= '0;
                last_end_reg    <= '0;
                seen_match_reg  <= 1'b0;
                too_long_reg    <= 1'b0;
            end else begin
                window_reg      <= window_next;
                position_reg    <= position_next;
                first_start_reg <= first_start_next;
                last_end_reg    <= last_end_next;
                seen_match_reg  <= seen_match_next;
                too_long_reg    <= too_long_next;
            end
        end
    end

endmodule

// File: hdl/repeat_tract_end_trimmer_unit.sv
// Repeat tract end trimmer: takes a tract one character per request and tests the
// newest motif_len characters against every rotation of the configured motif after
// each one, including the final window. The request carrying is_last produces one
// result with found, the start of the earliest match, the end of the latest match
// (both saturated at 4095, zero when nothing matched) and overlong when more than
// MAX_TRACT characters arrived. One character is taken per clock unless the input is
// blocked: an accepted request waits in the input register while the rotation compare
// and the tract state update run, and an is_last result goes to the output register.
// A request carrying is_last waits in the input register, and blocks the input, for as
// long as an earlier result is still unaccepted on the output. The user must write the
// motif registers (cfg_addr 0 motif_chars, 1 motif_len, via cfg_we/cfg_wdata)
// only while no request is held in the input register; the block does not enforce it.
module repeat_tract_end_trimmer_unit #(
    parameter int MAX_MOTIF = rtet_pkg::MAX_MOTIF_DEF,
    parameter int MAX_TRACT = rtet_pkg::MAX_TRACT_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_addr,
    input  logic [rtet_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  rtet_pkg::in_t              s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output rtet_pkg::out_t             m_data
);

    logic           in_valid_reg, in_valid_next;
    rtet_pkg::in_t  in_data_reg;
    logic           m_valid_reg,  m_valid_next;
    rtet_pkg::out_t m_data_reg;

    rtet_pkg::out_t result;
    logic           out_free;
    logic           proc_fire;

    assign out_free  = !m_valid_reg || m_ready;
    assign proc_fire = in_valid_reg && (!in_data_reg.is_last || out_free);
    assign s_ready   = !in_valid_reg || proc_fire;

    rtet_core #(
        .MAX_MOTIF (MAX_MOTIF),
        .MAX_TRACT (MAX_TRACT)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .step      (proc_fire),
        .item      (in_data_reg),
        .result    (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (proc_fire && in_data_reg.is_last) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (proc_fire && in_data_reg.is_last) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    // an empty result never carries positions
    a_nomatch_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.trim_begin == '0 && m_data.trim_end == '0)
        else $error("result without match carries nonzero positions");

    // earliest start never lies past latest end
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.found |-> m_data.trim_begin <= m_data.trim_end)
        else $error("trim_begin beyond trim_end");

    // an accepted request is held in the input register next cycle
    a_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg)
        else $error("accepted request lost");

    // a stalled last request keeps the input side blocked
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && in_data_reg.is_last && m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while last request stalled");
`endif

endmodule
